// ===== rtl/ifeq_pkg.sv =====
// Shared widths, types and reset constants of the interval frequency estimator.
package ifeq_pkg;

   localparam int SEQ_W  = 32;
   localparam int CNT_W  = 32;
   localparam int MEAN_W = 40;
   localparam int ERR_W  = 41;
   localparam int FRAC_W = 8;

   localparam int WINDOW_SPAN_DEFAULT = 16;
   localparam int BLOCK_SPAN_DEFAULT  = 16;

   localparam logic [CNT_W-1:0] NOMINAL_RESET = CNT_W'(10000000);

   typedef logic [SEQ_W-1:0]         seq_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [MEAN_W-1:0]        mean_type;
   typedef logic signed [ERR_W-1:0]  error_type;

endpackage

// ===== rtl/ifeq_channels.sv =====
// Handshake channel interfaces: request items, result items and the register write port.
interface ifeq_req_if;
   import ifeq_pkg::*;

   logic      valid;
   logic      ready;
   seq_type   close_seq;
   count_type edge_count;
   logic      gate_ok;

   modport source (output valid, output close_seq, output edge_count,
                   output gate_ok, input ready);
   modport sink   (input valid, input close_seq, input edge_count,
                   input gate_ok, output ready);
endinterface

interface ifeq_rsp_if;
   import ifeq_pkg::*;

   logic      valid;
   logic      ready;
   seq_type   echo_seq;
   logic      window_ready;
   mean_type  window_mean;
   seq_type   window_first_sequence;
   logic      block_ready;
   mean_type  block_mean;
   error_type block_error;
   seq_type   block_first_sequence;

   modport source (output valid, output echo_seq, output window_ready,
                   output window_mean, output window_first_sequence,
                   output block_ready, output block_mean, output block_error,
                   output block_first_sequence, input ready);
   modport sink   (input valid, input echo_seq, input window_ready,
                   input window_mean, input window_first_sequence,
                   input block_ready, input block_mean, input block_error,
                   input block_first_sequence, output ready);
endinterface

interface ifeq_csr_if;
   import ifeq_pkg::*;

   logic      valid;
   logic      ready;
   count_type nominal_count;

   modport source (output valid, output nominal_count, input ready);
   modport sink   (input valid, input nominal_count, output ready);
endinterface

// ===== rtl/ifeq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module ifeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ifeq_mean_div.sv =====
// Three-stage pipelined fixed-point mean: floor(dividend * 2^FRAC / SPAN) by reciprocal.
module ifeq_mean_div #(
   parameter int SPAN  = 16,
   parameter int IN_W  = 36,
   parameter int OUT_W = 40,
   parameter int FRAC  = 8
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [IN_W-1:0]  dividend,
   output logic [OUT_W-1:0] quotient
);

   localparam int N    = IN_W + FRAC;
   localparam int K    = N + $clog2(SPAN);
   localparam int MW   = N + 1;
   localparam int P_W  = IN_W + MW;
   localparam int DL   = (IN_W + 1) / 2;
   localparam int DH   = IN_W - DL;
   localparam int ML   = (MW + 1) / 2;
   localparam int MH   = MW - ML;

   localparam logic [K:0]    POW        = (K+1)'(1) << K;
   localparam logic [K:0]    RECIP_FULL = (POW + (K+1)'(SPAN - 1)) / (K+1)'(SPAN);
   localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];
   localparam logic [ML-1:0] RECIP_LO   = RECIP[ML-1:0];
   localparam logic [MH-1:0] RECIP_HI   = RECIP[MW-1:ML];

   logic [DL+ML-1:0] pll_ff;
   logic [DL+MH-1:0] plh_ff;
   logic [DH+ML-1:0] phl_ff;
   logic [DH+MH-1:0] phh_ff;
   logic [P_W-1:0]   sa_ff;
   logic [P_W-1:0]   sb_ff;
   logic [P_W-1:0]   total;
   logic [OUT_W-1:0] quotient_ff;

   assign total = sa_ff + sb_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pll_ff      <= (DL+ML)'(dividend[DL-1:0]) * (DL+ML)'(RECIP_LO);
         plh_ff      <= (DL+MH)'(dividend[DL-1:0]) * (DL+MH)'(RECIP_HI);
         phl_ff      <= (DH+ML)'(dividend[IN_W-1:DL]) * (DH+ML)'(RECIP_LO);
         phh_ff      <= (DH+MH)'(dividend[IN_W-1:DL]) * (DH+MH)'(RECIP_HI);
         sa_ff       <= P_W'(pll_ff) + (P_W'(plh_ff) << ML);
         sb_ff       <= (P_W'(phl_ff) << DL) + (P_W'(phh_ff) << (DL + ML));
         quotient_ff <= total[K-FRAC +: OUT_W];
      end
   end

   assign quotient = quotient_ff;

endmodule

// ===== rtl/interval_frequency_estimator_core.sv =====
// Top level of the interval frequency estimator: sliding window and block means of edge counts.
//
// Each request item carries one gate interval: its closing sequence, edge count and a
// valid flag. Every request item gives exactly one result item on the rsp channel.
// An invalid item or a zero count clears the window and the block accumulator; its
// result echoes the sequence with all other fields zero. Once the window holds
// WINDOW_SPAN counts each result carries the window mean (8 fraction bits) and the
// sequence before the window's first interval. Every BLOCK_SPAN intervals a result
// carries the block mean, the block error against BLOCK_SPAN times the nominal count,
// and the sequence before the block's first interval; the block then restarts.
// The csr channel writes the nominal count; it is always ready. The user must write it
// only while no item is in flight; the block itself does not enforce this.
// Throughput: one item per cycle while the receiver does not stall. A request item
// passes the count-ring read, then the update of the ring and running sums, then the
// reciprocal multiply of the means (partial products, partial sums, quotient).
// When the receiver stalls, the whole pipeline holds and req ready drops.
// Reset clears the running state and loads the nominal count of 10000000; ring
// contents are not cleared and need no clearing pass.
module interval_frequency_estimator_core #(
   parameter int WINDOW_SPAN = ifeq_pkg::WINDOW_SPAN_DEFAULT,
   parameter int BLOCK_SPAN  = ifeq_pkg::BLOCK_SPAN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ifeq_req_if.sink    req_ch,
   ifeq_rsp_if.source  rsp_ch,
   ifeq_csr_if.sink    csr_ch
);
   import ifeq_pkg::*;

   localparam int PTR_W   = (WINDOW_SPAN > 1) ? $clog2(WINDOW_SPAN) : 1;
   localparam int WFILL_W = $clog2(WINDOW_SPAN + 1);
   localparam int BFILL_W = $clog2(BLOCK_SPAN + 1);
   localparam int WSUM_W  = CNT_W + $clog2(WINDOW_SPAN);
   localparam int BSUM_W  = CNT_W + $clog2(BLOCK_SPAN);
   localparam int EXP_W   = CNT_W + $clog2(BLOCK_SPAN);

   localparam logic [EXP_W-1:0] EXPECT_RESET = EXP_W'(EXP_W'(NOMINAL_RESET) * EXP_W'(BLOCK_SPAN));

   typedef struct packed {
      seq_type echo_seq;
      logic    window_ready;
      seq_type window_first_sequence;
      logic    block_ready;
      seq_type block_first_sequence;
   } side_type;

   logic en;
   logic accept;
   logic req_ok;

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               fwd_ff;
   count_type          fwd_data_ff;

   logic               s1_v_ff;
   seq_type            s1_seq_ff;
   count_type          s1_cnt_ff;
   logic               s1_ok_ff;
   logic [PTR_W-1:0]   s1_slot_ff;

   logic [WSUM_W-1:0]  wsum_ff;
   logic [WFILL_W-1:0] wfill_ff;
   seq_type            wstart_ff;
   logic [BSUM_W-1:0]  bsum_ff;
   logic [BFILL_W-1:0] bfill_ff;
   seq_type            bstart_ff;
   logic [EXP_W-1:0]   expect_ff;

   count_type          ram_rd_data;
   count_type          old_cnt;
   logic               wfull;
   seq_type            wstart_base;
   logic [WFILL_W-1:0] wfill_nx;
   seq_type            wstart_nx;
   logic [WSUM_W-1:0]  wsum_nx;
   logic               wready;
   seq_type            bstart_nx;
   logic [BSUM_W-1:0]  bsum_acc;
   logic [BFILL_W-1:0] bfill_acc;
   logic               bdone;
   logic               s1_update;

   logic               p1_v_ff;
   side_type           p1_side_ff, p1_side_in;
   logic [WSUM_W-1:0]  p1_wsum_ff;
   logic [BSUM_W-1:0]  p1_bsum_ff;
   logic               p2_v_ff;
   side_type           p2_side_ff;
   error_type          p2_err_ff, p2_err_in;
   logic               p3_v_ff;
   side_type           p3_side_ff;
   error_type          p3_err_ff;
   logic               rsp_v_ff;
   side_type           rsp_side_ff;
   error_type          rsp_err_ff;
   mean_type           wmean;
   mean_type           bmean;

   assign en       = !rsp_v_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && en;
   assign req_ok   = req_ch.gate_ok && (req_ch.edge_count != '0);
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      ptr_in = ptr_ff;
      if (accept) begin
         if (!req_ok || (ptr_ff == PTR_W'(WINDOW_SPAN - 1))) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end
   end

   ifeq_ram #(
      .WIDTH (CNT_W),
      .DEPTH (WINDOW_SPAN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_update && s1_ok_ff),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_cnt_ff),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign s1_update = s1_v_ff && en;

   always_comb begin
      old_cnt     = fwd_ff ? fwd_data_ff : ram_rd_data;
      wfull       = (wfill_ff == WFILL_W'(WINDOW_SPAN));
      wstart_base = (wfill_ff == '0) ? (s1_seq_ff - SEQ_W'(1)) : wstart_ff;
      wfill_nx    = wfull ? wfill_ff : (wfill_ff + WFILL_W'(1));
      wstart_nx   = wfull ? (wstart_base + SEQ_W'(1)) : wstart_base;
      wsum_nx     = wsum_ff - (wfull ? WSUM_W'(old_cnt) : '0) + WSUM_W'(s1_cnt_ff);
      wready      = s1_ok_ff && (wfill_nx == WFILL_W'(WINDOW_SPAN));
      bstart_nx   = (bfill_ff == '0) ? (s1_seq_ff - SEQ_W'(1)) : bstart_ff;
      bsum_acc    = bsum_ff + BSUM_W'(s1_cnt_ff);
      bfill_acc   = bfill_ff + BFILL_W'(1);
      bdone       = s1_ok_ff && (bfill_acc == BFILL_W'(BLOCK_SPAN));

      p1_side_in.echo_seq              = s1_seq_ff;
      p1_side_in.window_ready          = wready;
      p1_side_in.window_first_sequence = wready ? wstart_nx : '0;
      p1_side_in.block_ready           = bdone;
      p1_side_in.block_first_sequence  = bdone ? bstart_nx : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         fwd_ff    <= 1'b0;
         s1_v_ff   <= 1'b0;
         wsum_ff   <= '0;
         wfill_ff  <= '0;
         wstart_ff <= '0;
         bsum_ff   <= '0;
         bfill_ff  <= '0;
         bstart_ff <= '0;
         expect_ff <= EXPECT_RESET;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         p3_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (csr_ch.valid) begin
            expect_ff <= EXP_W'(EXP_W'(csr_ch.nominal_count) * EXP_W'(BLOCK_SPAN));
         end
         // forward a write that lands on the slot being read at the same edge
         if (accept) begin
            fwd_ff <= s1_update && s1_ok_ff && (s1_slot_ff == ptr_ff);
         end
         if (s1_update) begin
            if (!s1_ok_ff) begin
               wsum_ff   <= '0;
               wfill_ff  <= '0;
               wstart_ff <= '0;
               bsum_ff   <= '0;
               bfill_ff  <= '0;
               bstart_ff <= '0;
            end else begin
               wsum_ff   <= wsum_nx;
               wfill_ff  <= wfill_nx;
               wstart_ff <= wstart_nx;
               bsum_ff   <= bdone ? '0 : bsum_acc;
               bfill_ff  <= bdone ? '0 : bfill_acc;
               bstart_ff <= bstart_nx;
            end
         end
         if (en) begin
            s1_v_ff  <= req_ch.valid;
            p1_v_ff  <= s1_v_ff;
            p2_v_ff  <= p1_v_ff;
            p3_v_ff  <= p2_v_ff;
            rsp_v_ff <= p3_v_ff;
         end
      end
   end

   assign p2_err_in = p1_side_ff.block_ready ?
                      $signed(ERR_W'(p1_bsum_ff) - ERR_W'(expect_ff)) : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= s1_cnt_ff;
         s1_seq_ff   <= req_ch.close_seq;
         s1_cnt_ff   <= req_ch.edge_count;
         s1_ok_ff    <= req_ok;
         s1_slot_ff  <= ptr_ff;
      end
      if (en) begin
         p1_side_ff  <= p1_side_in;
         p1_wsum_ff  <= wready ? wsum_nx : '0;
         p1_bsum_ff  <= bdone ? bsum_acc : '0;
         p2_side_ff  <= p1_side_ff;
         p2_err_ff   <= p2_err_in;
         p3_side_ff  <= p2_side_ff;
         p3_err_ff   <= p2_err_ff;
         rsp_side_ff <= p3_side_ff;
         rsp_err_ff  <= p3_err_ff;
      end
   end

   ifeq_mean_div #(
      .SPAN  (WINDOW_SPAN),
      .IN_W  (WSUM_W),
      .OUT_W (MEAN_W),
      .FRAC  (FRAC_W)
   ) u_window_div (
      .clock    (clock),
      .advance  (en),
      .dividend (p1_wsum_ff),
      .quotient (wmean)
   );

   ifeq_mean_div #(
      .SPAN  (BLOCK_SPAN),
      .IN_W  (BSUM_W),
      .OUT_W (MEAN_W),
      .FRAC  (FRAC_W)
   ) u_block_div (
      .clock    (clock),
      .advance  (en),
      .dividend (p1_bsum_ff),
      .quotient (bmean)
   );

   assign rsp_ch.valid                 = rsp_v_ff;
   assign rsp_ch.echo_seq              = rsp_side_ff.echo_seq;
   assign rsp_ch.window_ready          = rsp_side_ff.window_ready;
   assign rsp_ch.window_mean           = wmean;
   assign rsp_ch.window_first_sequence = rsp_side_ff.window_first_sequence;
   assign rsp_ch.block_ready           = rsp_side_ff.block_ready;
   assign rsp_ch.block_mean            = bmean;
   assign rsp_ch.block_error           = rsp_err_ff;
   assign rsp_ch.block_first_sequence  = rsp_side_ff.block_first_sequence;

   a_wfill_bound: assert property (@(posedge clock) disable iff (reset)
      wfill_ff <= WFILL_W'(WINDOW_SPAN))
      else $error("window fill beyond span");

   a_bfill_bound: assert property (@(posedge clock) disable iff (reset)
      bfill_ff < BFILL_W'(BLOCK_SPAN))
      else $error("block fill reached span without restart");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_update && bdone) |=> (bfill_ff == '0) && (bsum_ff == '0))
      else $error("block accumulator not cleared after completion");

   a_clear_item: assert property (@(posedge clock) disable iff (reset)
      (s1_update && !s1_ok_ff) |=> (wfill_ff == '0) && (wsum_ff == '0))
      else $error("invalid item did not clear window state");

endmodule

// ===== bench/ifeq_estimate_checker.sv =====
// Channel monitor that predicts each estimator result and compares it field by field.
module ifeq_estimate_checker #(
   parameter int WINDOW_SPAN = ifeq_pkg::WINDOW_SPAN_DEFAULT,
   parameter int BLOCK_SPAN  = ifeq_pkg::BLOCK_SPAN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ifeq_req_if         req_ch,
   ifeq_rsp_if         rsp_ch,
   ifeq_csr_if         csr_ch,
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned results_checked,
   output int unsigned window_reports,
   output int unsigned block_reports
);
   import ifeq_pkg::*;

   typedef struct packed {
      seq_type   echo_seq;
      logic      window_ready;
      mean_type  window_mean;
      seq_type   window_first_sequence;
      logic      block_ready;
      mean_type  block_mean;
      error_type block_error;
      seq_type   block_first_sequence;
   } estimate_type;

   count_type    ring [WINDOW_SPAN];
   logic [63:0]  win_sum;
   logic [63:0]  blk_sum;
   int           win_fill;
   int           blk_fill;
   int           ring_ptr;
   seq_type      win_start;
   seq_type      blk_start;
   count_type    nominal;
   estimate_type awaited_estimates [$];

   function automatic void clear_estimator();
      foreach (ring[i]) ring[i] = '0;
      win_sum   = '0;
      blk_sum   = '0;
      win_fill  = 0;
      blk_fill  = 0;
      ring_ptr  = 0;
      win_start = '0;
      blk_start = '0;
   endfunction

   function automatic estimate_type advance_estimator(seq_type s, count_type c, logic v);
      estimate_type e;
      logic [63:0]  diff;
      e = '0;
      e.echo_seq = s;
      if (!v || c == '0) begin
         clear_estimator();
         return e;
      end
      if (win_fill == 0) win_start = s - 32'd1;
      if (win_fill < WINDOW_SPAN) begin
         win_fill++;
      end else begin
         win_sum   = win_sum - 64'(ring[ring_ptr]);
         win_start = win_start + 32'd1;
      end
      ring[ring_ptr] = c;
      win_sum  = win_sum + 64'(c);
      ring_ptr = (ring_ptr + 1) % WINDOW_SPAN;
      if (win_fill == WINDOW_SPAN) begin
         e.window_ready          = 1'b1;
         e.window_mean           = mean_type'((win_sum << FRAC_W) / 64'(WINDOW_SPAN));
         e.window_first_sequence = win_start;
      end
      if (blk_fill == 0) blk_start = s - 32'd1;
      blk_sum  = blk_sum + 64'(c);
      blk_fill++;
      if (blk_fill >= BLOCK_SPAN) begin
         diff = blk_sum - 64'(BLOCK_SPAN) * 64'(nominal);
         e.block_ready          = 1'b1;
         e.block_mean           = mean_type'((blk_sum << FRAC_W) / 64'(BLOCK_SPAN));
         e.block_error          = diff[ERR_W-1:0];
         e.block_first_sequence = blk_start;
         blk_sum  = '0;
         blk_fill = 0;
      end
      return e;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         clear_estimator();
         nominal = NOMINAL_RESET;
         awaited_estimates.delete();
         failures        = 0;
         results_checked = 0;
         window_reports  = 0;
         block_reports   = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) nominal = csr_ch.nominal_count;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_estimates.size() == 0) begin
               $error("result for sequence %0h with nothing awaited", rsp_ch.echo_seq);
               failures++;
            end else begin
               want = awaited_estimates.pop_front();
               check_field("echo_seq", want.echo_seq, rsp_ch.echo_seq);
               check_field("window_ready", want.window_ready, rsp_ch.window_ready);
               check_field("window_mean", want.window_mean, rsp_ch.window_mean);
               check_field("window_first_sequence", want.window_first_sequence,
                           rsp_ch.window_first_sequence);
               check_field("block_ready", want.block_ready, rsp_ch.block_ready);
               check_field("block_mean", want.block_mean, rsp_ch.block_mean);
               check_field("block_error", 64'(unsigned'(want.block_error)),
                           64'(unsigned'(rsp_ch.block_error)));
               check_field("block_first_sequence", want.block_first_sequence,
                           rsp_ch.block_first_sequence);
               results_checked++;
               if (want.window_ready) window_reports++;
               if (want.block_ready) block_reports++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited_estimates.push_back(advance_estimator(req_ch.close_seq,
                                                          req_ch.edge_count,
                                                          req_ch.gate_ok));
      end
      pending <= awaited_estimates.size();
   end

endmodule

// ===== bench/tb.sv =====
// Top of the estimator bench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
   import ifeq_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 60;
   localparam int PHASE_ITEMS  = 238;
   localparam int PHASE_COUNT  = 6;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned failures;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned window_reports;
   int unsigned block_reports;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int          burst_left = 0;
   bit          gapless = 1'b0;
   seq_type     next_seq;
   count_type   nominal_now;

   ifeq_req_if req_ch ();
   ifeq_rsp_if rsp_ch ();
   ifeq_csr_if csr_ch ();

   interval_frequency_estimator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ifeq_estimate_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .failures        (failures),
      .pending         (pending),
      .results_checked (results_checked),
      .window_reports  (window_reports),
      .block_reports   (block_reports)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ((mode_left % 5) < 2);
            endcase
         end
      end
   end

   task automatic offer(input seq_type s, input count_type c, input logic v);
      int gap;
      req_ch.valid      <= 1'b1;
      req_ch.close_seq  <= s;
      req_ch.edge_count <= c;
      req_ch.gate_ok    <= v;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (!gapless) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 20);
            gap        = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_nominal(input count_type value);
      drain();
      csr_ch.nominal_count <= value;
      csr_ch.valid         <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      nominal_now = value;
   endtask

   function automatic count_type pick_count(count_type centre);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         2: return $urandom_range(1, 15);
         default: return centre + $urandom_range(0, 4000) - 32'd2000;
      endcase
   endfunction

   task automatic random_item();
      int        draw;
      logic      v;
      count_type c;
      draw = $urandom_range(0, 99);
      if (draw == 0) begin
         v = 1'b0;
         c = $urandom();
      end else if (draw == 1) begin
         v = 1'b1;
         c = '0;
      end else begin
         v = 1'b1;
         c = pick_count(nominal_now);
      end
      draw = $urandom_range(0, 99);
      if (draw < 3) next_seq = $urandom();
      else if (draw == 3) next_seq = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else next_seq = next_seq + 32'd1;
      offer(next_seq, c, v);
   endtask

   task automatic run_phase();
      hold_requests++;
      gapless = 1'b1;
      repeat (24) random_item();
      gapless = 1'b0;
      for (int i = 0; i < PHASE_ITEMS - 24; i++) begin
         gapless = (i >= PHASE_ITEMS / 4 && i < PHASE_ITEMS / 4 + 30);
         random_item();
         if (i == PHASE_ITEMS / 2) drain();
      end
      gapless = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.close_seq     <= '0;
      req_ch.edge_count    <= '0;
      req_ch.gate_ok       <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.nominal_count <= '0;
      nominal_now = NOMINAL_RESET;
      next_seq    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      offer(32'h0000_1000, 32'hFFFF_FFFF, 1'b0);
      offer(32'h0000_1001, '0, 1'b1);
      for (int i = 0; i < 17; i++)
         offer(32'hFFFF_FFF8 + i, 32'hFFFF_FFFF, 1'b1);
      offer(32'hFFFF_FFFF, '0, 1'b0);
      for (int i = 0; i < 4; i++)
         offer(i, 32'd1, 1'b1);
      next_seq = 32'd3;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: ;
            1: set_nominal('0);
            2: set_nominal(32'hFFFF_FFFF);
            3: set_nominal(32'd1);
            4: set_nominal($urandom());
            default: set_nominal(NOMINAL_RESET);
         endcase
         run_phase();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d items over %0d nominal settings with receiver holds and drains",
               items_sent, PHASE_COUNT);
      $display("checked %0d results: %0d window means, %0d block reports",
               results_checked, window_reports, block_reports);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
